// ----- design/sacl_pkg.sv -----
// Shared types, constants and codes of the set-associative LRU cache model.
// No dependencies; every other design file uses this package.
package sacl_pkg;

    // Sizing of the cache arrays and of the address.
    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 64;

    // Fixed widths of the interface fields and of the configuration registers.
    localparam int IN_ADDR_W    = 64;
    localparam int KIND_W       = 2;
    localparam int CNT_W        = 32;
    localparam int SETB_W       = 3;
    localparam int WAYS_FIELD_W = 4;
    localparam int OFFB_W       = 6;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int REG_IDX_W    = APB_AW - 2;

    // Derived widths.
    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int REC_W   = WAY_W;
    localparam int LIM_W   = REC_W + 1;
    localparam int TAG_W   = ADDR_WIDTH;
    localparam int SBITS_W = $clog2(SET_W + 1);
    localparam int SHIFT_W = $clog2((2 ** OFFB_W) + SET_W);

    // Register word indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WAYS        = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = REG_IDX_W'(2);

    // Kind of one trace access.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_INSTR  = 2'd3
    } access_kind_t;

    // Configuration register contents.
    typedef struct packed {
        logic [SETB_W-1:0]       set_index_bits;
        logic [WAYS_FIELD_W-1:0] ways_in_use;
        logic [OFFB_W-1:0]       block_offset_bits;
    } cfg_t;

    // One set of the cache: valid bits, tags and recency ranks of all ways.
    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0][REC_W-1:0] rec;
    } line_row_t;

    // Outcome of one lookup.
    typedef struct packed {
        logic hit;
        logic miss;
        logic eviction;
    } access_flags_t;

endpackage

// ----- design/sacl_ifs.sv -----
// Valid/ready channel interfaces for trace accesses and lookup results.
// Depends on sacl_pkg for the field widths.
interface sacl_access_if;
    logic                           valid;
    logic                           ready;
    logic [sacl_pkg::IN_ADDR_W-1:0] address;
    logic [sacl_pkg::KIND_W-1:0]    access_kind;

    modport source (output valid, output address, output access_kind, input ready);
    modport sink   (input valid, input address, input access_kind, output ready);
endinterface

interface sacl_result_if;
    logic                       valid;
    logic                       ready;
    logic                       was_hit;
    logic                       was_miss;
    logic                       was_eviction;
    logic [sacl_pkg::CNT_W-1:0] hit_total;
    logic [sacl_pkg::CNT_W-1:0] miss_total;
    logic [sacl_pkg::CNT_W-1:0] eviction_total;

    modport source (output valid, output was_hit, output was_miss, output was_eviction,
                    output hit_total, output miss_total, output eviction_total,
                    input ready);
    modport sink   (input valid, input was_hit, input was_miss, input was_eviction,
                    input hit_total, input miss_total, input eviction_total,
                    output ready);
endinterface

// ----- design/sacl_cfg_regs.sv -----
// APB-style configuration registers: set index bits, ways in use, offset bits.
// Depends on sacl_pkg for the register layout and codes.
module sacl_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sacl_pkg::APB_AW-1:0] paddr,
    input  logic [sacl_pkg::APB_DW-1:0] pwdata,
    output logic [sacl_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output sacl_pkg::cfg_t              cfg
);
    import sacl_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] word_idx;
    logic                 wr_fire;

    assign pready   = 1'b1;
    assign word_idx = paddr[APB_AW-1:2];
    assign wr_fire  = psel & penable & pwrite;

    // Register write decode; writes to unused words are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_fire)
        begin
            unique case (word_idx)
                REG_SET_BITS:    cfg_next.set_index_bits    = pwdata[SETB_W-1:0];
                REG_WAYS:        cfg_next.ways_in_use       = pwdata[WAYS_FIELD_W-1:0];
                REG_OFFSET_BITS: cfg_next.block_offset_bits = pwdata[OFFB_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_index_bits    <= SETB_W'(1);
            cfg_reg.ways_in_use       <= WAYS_FIELD_W'(1);
            cfg_reg.block_offset_bits <= OFFB_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (word_idx)
            REG_SET_BITS:    prdata = APB_DW'(cfg_reg.set_index_bits);
            REG_WAYS:        prdata = APB_DW'(cfg_reg.ways_in_use);
            REG_OFFSET_BITS: prdata = APB_DW'(cfg_reg.block_offset_bits);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/sacl_line_store.sv -----
// Cache line store: valid, tag and recency memories with one row per set, and
// per-set written flags cleared at reset so that an unwritten set reads as empty.
// Depends on sacl_pkg.
module sacl_line_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [sacl_pkg::SET_W-1:0] rd_set,
    output sacl_pkg::line_row_t        rd_row,
    input  logic                       wr_en,
    input  logic [sacl_pkg::SET_W-1:0] wr_set,
    input  sacl_pkg::line_row_t        wr_row
);
    import sacl_pkg::*;

    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][REC_W-1:0] rec_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]            valid_mem [MAX_SETS];
    logic [MAX_SETS-1:0]            set_written_reg;

    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tag_reg;
    logic [MAX_WAYS-1:0][REC_W-1:0] rd_rec_reg;
    logic [MAX_WAYS-1:0]            rd_valid_reg;
    logic                           rd_written_reg;

    // One flag per set marks rows written since reset, so reset empties the
    // cache at once without touching the memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_written_reg <= '0;
            rd_written_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                set_written_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= set_written_reg[rd_set];
            end
        end
    end

    // Valid, tag and recency memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_set] <= wr_row.valid;
            tag_mem[wr_set]   <= wr_row.tag;
            rec_mem[wr_set]   <= wr_row.rec;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_set];
            rd_tag_reg   <= tag_mem[rd_set];
            rd_rec_reg   <= rec_mem[rd_set];
        end
    end

    // A set never written since reset holds no valid line.
    assign rd_row = '{valid: (rd_written_reg ? rd_valid_reg : '0),
                      tag:   rd_tag_reg,
                      rec:   rd_rec_reg};

endmodule

// ----- design/sacl_update.sv -----
// Lookup and LRU update of one set: tag compare over the ways in use, fill of
// the first free way or eviction of the oldest way, and recency aging.
// Depends on sacl_pkg.
module sacl_update (
    input  sacl_pkg::line_row_t               row_in,
    input  logic [sacl_pkg::TAG_W-1:0]        tag,
    input  logic [sacl_pkg::WAYS_FIELD_W-1:0] ways_in_use,
    output sacl_pkg::line_row_t               row_out,
    output sacl_pkg::access_flags_t           flags
);
    import sacl_pkg::*;

    logic [MAX_WAYS-1:0]            way_en;
    logic [MAX_WAYS-1:0]            hit_vec;
    logic [MAX_WAYS-1:0]            free_vec;
    logic [MAX_WAYS-1:0][REC_W-1:0] rec_eff;
    logic                           hit;
    logic                           have_free;
    logic [WAY_W-1:0]               hit_way;
    logic [WAY_W-1:0]               free_way;
    logic [WAY_W-1:0]               victim_way;
    logic [WAY_W-1:0]               target_way;
    logic [LIM_W-1:0]               limit;

    // Per-way match and free status. A zero way count still uses way zero.
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_en[w]   = (w == 0) || (int'(ways_in_use) > w);
            rec_eff[w]  = row_in.valid[w] ? row_in.rec[w] : '0;
            hit_vec[w]  = way_en[w] & row_in.valid[w] & (row_in.tag[w] == tag);
            free_vec[w] = way_en[w] & ~row_in.valid[w];
        end
    end

    // Lowest-numbered hit and free ways.
    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                free_way = WAY_W'(w);
            end
        end
    end

    // Oldest way in use; on equal rank the lower way wins.
    always_comb
    begin
        victim_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (way_en[w] && (rec_eff[w] > rec_eff[victim_way]))
            begin
                victim_way = WAY_W'(w);
            end
        end
    end

    assign hit       = |hit_vec;
    assign have_free = |free_vec;

    // Pick the way that is touched and the aging limit.
    always_comb
    begin
        priority if (hit)
        begin
            target_way = hit_way;
            limit      = LIM_W'(rec_eff[hit_way]);
        end
        else if (have_free)
        begin
            target_way = free_way;
            limit      = LIM_W'(MAX_WAYS);
        end
        else
        begin
            target_way = victim_way;
            limit      = LIM_W'(MAX_WAYS);
        end
    end

    // Age the younger valid ways, then make the touched way most recent.
    always_comb
    begin
        row_out = row_in;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (way_en[w] && row_in.valid[w] && ({1'b0, row_in.rec[w]} < limit) &&
                (row_in.rec[w] < REC_W'(MAX_WAYS - 1)))
            begin
                row_out.rec[w] = row_in.rec[w] + REC_W'(1);
            end
        end
        row_out.rec[target_way] = '0;
        if (!hit)
        begin
            row_out.tag[target_way]   = tag;
            row_out.valid[target_way] = 1'b1;
        end
    end

    assign flags.hit      = hit;
    assign flags.miss     = ~hit;
    assign flags.eviction = ~hit & ~have_free;

endmodule

// ----- design/set_assoc_lru_cache_sim_unit.sv -----
// Top level of the set-associative cache with true LRU replacement.
// Depends on sacl_pkg, sacl_ifs, sacl_cfg_regs, sacl_line_store, sacl_update.
//
// Usage:
//   access  - input channel, one beat per trace access (address, access_kind).
//   result  - output channel, one beat per load, store or modify with the hit,
//             miss and eviction flags and the saturating running totals.
//             Instruction accesses are taken and produce no beat.
//   APB     - three registers at byte addresses 0, 4 and 8: set index bits,
//             ways in use, block offset bits. Write them only while idle.
// Timing: an accepted beat reads its set from the line store at the accept
// edge; in the update stage it then compares, updates and writes the set
// back and loads the result register, unless a waiting result beat stalls it.
// A new access is taken only after the last one leaves the update stage,
// since the set row in the line store is read, modified and written back.
// Reset empties all lines, clears the totals and sets each register to 1.
// When the receiver stalls, one more load, store or modify is accepted and then
// held in the update stage until the waiting result beat is taken.
module set_assoc_lru_cache_sim_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    sacl_access_if.sink                 access,
    sacl_result_if.source               result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sacl_pkg::APB_AW-1:0] paddr,
    input  logic [sacl_pkg::APB_DW-1:0] pwdata,
    output logic [sacl_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sacl_pkg::*;

    cfg_t                cfg;
    logic                accept;
    logic                fire;
    logic                load_result;
    logic                busy_reg;
    logic                busy_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    access_kind_t        kind_reg;
    logic [ADDR_WIDTH-1:0] addr_w;
    logic [ADDR_WIDTH-1:0] addr_shifted;
    logic [SBITS_W-1:0]  sbits_eff;
    logic [SET_W-1:0]    set_mask;
    logic [SHIFT_W-1:0]  tag_shift;
    logic [SET_W-1:0]    in_set;
    logic [TAG_W-1:0]    in_tag;
    line_row_t           rd_row;
    line_row_t           wr_row;
    access_flags_t       flags;
    logic [1:0]          hit_inc;
    logic                is_modify;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    evict_cnt_reg;
    logic                was_hit_reg;
    logic                was_miss_reg;
    logic                was_evict_reg;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    sacl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Split the incoming address into set and tag by the configured widths.
    always_comb
    begin
        addr_w       = access.address[ADDR_WIDTH-1:0];
        addr_shifted = addr_w >> cfg.block_offset_bits;
        if (int'(cfg.set_index_bits) > SET_W)
        begin
            sbits_eff = SBITS_W'(SET_W);
        end
        else
        begin
            sbits_eff = SBITS_W'(cfg.set_index_bits);
        end
        set_mask  = ~({SET_W{1'b1}} << sbits_eff);
        in_set    = addr_shifted[SET_W-1:0] & set_mask;
        tag_shift = SHIFT_W'(cfg.block_offset_bits) + SHIFT_W'(sbits_eff);
        in_tag    = TAG_W'(addr_w >> tag_shift);
    end

    // Handshake: one access in the update stage at a time.
    assign access.ready = ~busy_reg;
    assign accept       = access.valid & ~busy_reg;
    assign fire         = busy_reg & ((kind_reg == KIND_INSTR) | ~res_valid_reg | result.ready);
    assign load_result  = fire & (kind_reg != KIND_INSTR);

    sacl_line_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (in_set),
        .rd_row (rd_row),
        .wr_en  (load_result),
        .wr_set (set_reg),
        .wr_row (wr_row)
    );

    sacl_update u_update (
        .row_in      (rd_row),
        .tag         (tag_reg),
        .ways_in_use (cfg.ways_in_use),
        .row_out     (wr_row),
        .flags       (flags)
    );

    // A modify is a second access that always hits.
    assign is_modify = (kind_reg == KIND_MODIFY);
    assign hit_inc   = {1'b0, flags.hit} + {1'b0, is_modify};

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        priority if (load_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state and running totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            if (load_result)
            begin
                hit_cnt_reg   <= sat_add(hit_cnt_reg, hit_inc);
                miss_cnt_reg  <= sat_add(miss_cnt_reg, {1'b0, flags.miss});
                evict_cnt_reg <= sat_add(evict_cnt_reg, {1'b0, flags.eviction});
            end
        end
    end

    // Input register and result flag register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg  <= in_set;
            tag_reg  <= in_tag;
            kind_reg <= access_kind_t'(access.access_kind);
        end
        if (load_result)
        begin
            was_hit_reg   <= flags.hit | is_modify;
            was_miss_reg  <= flags.miss;
            was_evict_reg <= flags.eviction;
        end
    end

    // The totals change only when a result is loaded, so they drive the beat.
    assign result.valid          = res_valid_reg;
    assign result.was_hit        = was_hit_reg;
    assign result.was_miss       = was_miss_reg;
    assign result.was_eviction   = was_evict_reg;
    assign result.hit_total      = hit_cnt_reg;
    assign result.miss_total     = miss_cnt_reg;
    assign result.eviction_total = evict_cnt_reg;

    // Every result beat reports either a hit or a miss.
    a_hit_or_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.was_hit || result.was_miss))
        else $error("result beat with neither hit nor miss");

    // An eviction only follows a miss.
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.was_eviction) |-> result.was_miss)
        else $error("eviction reported without a miss");

    // The line store is written only from the update stage.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> busy_reg)
        else $error("line store written with no access in the update stage");

    // Totals hold unless a result is loaded.
    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load_result |=> ($stable(hit_cnt_reg) && $stable(miss_cnt_reg) &&
                          $stable(evict_cnt_reg)))
        else $error("running totals changed without a result");

    // A hit advances the hit total unless it is saturated.
    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (load_result && flags.hit) |=> ((hit_cnt_reg != $past(hit_cnt_reg)) ||
                                        (&hit_cnt_reg)))
        else $error("hit not counted");

endmodule
